// File: hdl/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// shared types, codes and sizes of the link address translator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lat_pkg;

  // prefix table depth, 1 to 32
  localparam int TableEntries = 32;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CountW       = $clog2(TableEntries + 1);

  localparam int EthW  = 48;
  localparam int LongW = 64;
  localparam int KeyW  = 24;
  localparam int PathW = 3;
  localparam int SlotW = 5;
  localparam int CfgIdxW = 2;

  // operations
  localparam logic OP_LONG_TO_ETH = 1'b0;
  localparam logic OP_ETH_TO_LONG = 1'b1;

  // path codes
  localparam logic [PathW-1:0] PATH_OWN    = 3'd0;
  localparam logic [PathW-1:0] PATH_DIRECT = 3'd1;
  localparam logic [PathW-1:0] PATH_HIT    = 3'd2;
  localparam logic [PathW-1:0] PATH_NEW    = 3'd3;
  localparam logic [PathW-1:0] PATH_FULL   = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_OWN_ETH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OWN_LONG = 2'd1;

  // byte 0 flag bits
  localparam int BitTr = 2;
  localparam int BitGl = 1;
  localparam int BitMu = 0;

  localparam logic [7:0] ByteFf = 8'hff;
  localparam logic [7:0] ByteFe = 8'hfe;

  typedef struct packed {
    logic start;    // restart the scan at slot 0
    logic advance;  // step to the next slot
  } lat_scan_ctrl_t;

  typedef struct packed {
    logic hit;      // entry under compare matches the key
    logic last;     // entry under compare is the last valid one
  } lat_scan_status_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_EMIT  = 5'b10000
  } lat_state_t;

endpackage

// File: hdl/lat_prefix_ram.sv
// ----------------------------------------------------------------------------
// lat_prefix_ram
// prefix table storage, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lat_prefix_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [lat_pkg::IdxW-1:0] wr_addr,
  input  logic [lat_pkg::KeyW-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [lat_pkg::IdxW-1:0] rd_addr,
  output logic [lat_pkg::KeyW-1:0] rd_data
);

  logic [lat_pkg::KeyW-1:0] mem [lat_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/lat_scan_unit.sv
// ----------------------------------------------------------------------------
// lat_scan_unit
// slot counter and key comparator shared across the table search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lat_scan_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lat_pkg::lat_scan_ctrl_t    ctrl,
  input  logic [lat_pkg::KeyW-1:0]   key,
  input  logic [lat_pkg::KeyW-1:0]   rd_data,
  input  logic [lat_pkg::CountW-1:0] count,
  output logic [lat_pkg::IdxW-1:0]   idx,
  output logic [lat_pkg::IdxW-1:0]   rd_addr,
  output lat_pkg::lat_scan_status_t  status
);

  logic [lat_pkg::IdxW-1:0]   idx_r;
  logic [lat_pkg::IdxW-1:0]   idx_nxt;
  logic [lat_pkg::CountW:0]   idx_inc;

  assign idx_inc = {{(lat_pkg::CountW + 1 - lat_pkg::IdxW){1'b0}}, idx_r} + 1'b1;

  // prefetch the entry after the one under compare
  assign rd_addr = ctrl.start ? '0 : idx_inc[lat_pkg::IdxW-1:0];

  assign status.hit  = (rd_data == key);
  assign status.last = (idx_inc == {1'b0, count});

  always_comb begin
    idx_nxt = idx_r;
    if (ctrl.start) begin
      idx_nxt = '0;
    end else if (ctrl.advance) begin
      idx_nxt = idx_inc[lat_pkg::IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

// File: hdl/link_address_translator_core.sv
// ----------------------------------------------------------------------------
// link_address_translator_core
// 802.15.4 long address to ethernet address translation and back
// ----------------------------------------------------------------------------
// One item at a time. Ethernet-to-long items, own-address items and direct
// copies go from acceptance via the result register and the emit step to the
// output register. Other long-to-ethernet items, after a fetch step, scan
// the prefix table one entry per cycle up to a hit or the last valid entry,
// through a single comparator fed by the table's registered read port; a
// write step then stores the entry before the emit step. A miss with no
// entries goes straight to the write step. in_stall is high while an item
// is at work; a finished result waits in the output register, and a new item
// is taken meanwhile. The table needs no clearing after reset. Configuration
// writes are always ready; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module link_address_translator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lat_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [lat_pkg::LongW-1:0]   cfg_data,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [lat_pkg::LongW-1:0]   in_long_address_in,
  input  logic [lat_pkg::EthW-1:0]    in_eth_address_in,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lat_pkg::EthW-1:0]    out_eth_address_out,
  output logic [lat_pkg::LongW-1:0]   out_long_address_out,
  output logic [lat_pkg::PathW-1:0]   out_path_taken,
  output logic [lat_pkg::SlotW-1:0]   out_table_slot
);

  // configuration registers
  logic [lat_pkg::EthW-1:0]  own_eth_r;
  logic [lat_pkg::LongW-1:0] own_long_r;

  // control state
  lat_pkg::lat_state_t         state_r, state_nxt;
  logic [lat_pkg::CountW-1:0]  count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // item held during the search
  logic [lat_pkg::KeyW-1:0]  key_r, key_nxt;
  logic [15:0]               mid_r, mid_nxt;   // long bytes 1 and 2
  logic [23:0]               low_r, low_nxt;   // long bytes 5 to 7
  logic                      hit_r, hit_nxt;
  logic [lat_pkg::IdxW-1:0]  hit_slot_r, hit_slot_nxt;

  // finished result before the output register
  logic [lat_pkg::EthW-1:0]  res_eth_r, res_eth_nxt;
  logic [lat_pkg::LongW-1:0] res_long_r, res_long_nxt;
  logic [lat_pkg::PathW-1:0] res_path_r, res_path_nxt;
  logic [lat_pkg::SlotW-1:0] res_slot_r, res_slot_nxt;

  // output register
  logic [lat_pkg::EthW-1:0]  out_eth_r, out_eth_nxt;
  logic [lat_pkg::LongW-1:0] out_long_r, out_long_nxt;
  logic [lat_pkg::PathW-1:0] out_path_r, out_path_nxt;
  logic [lat_pkg::SlotW-1:0] out_slot_r, out_slot_nxt;

  // table and scan unit wiring
  logic                       ram_wr_en;
  logic [lat_pkg::IdxW-1:0]   ram_wr_addr;
  logic                       ram_rd_en;
  logic [lat_pkg::IdxW-1:0]   ram_rd_addr;
  logic [lat_pkg::KeyW-1:0]   ram_rd_data;
  lat_pkg::lat_scan_ctrl_t    scan_ctrl;
  lat_pkg::lat_scan_status_t  scan_status;
  logic [lat_pkg::IdxW-1:0]   scan_idx;

  // decode of the arriving item
  logic                       accept;
  logic [7:0]                 lb0, lb3, lb4;
  logic                       direct_ok;
  logic                       out_free;
  logic [lat_pkg::IdxW-1:0]   wr_slot;
  logic [lat_pkg::PathW-1:0]  wr_path;
  logic                       table_full;

  // widen a table slot to the slot field
  function automatic logic [lat_pkg::SlotW-1:0] wr_slot_ext(
    input logic [lat_pkg::IdxW-1:0] s
  );
    wr_slot_ext = lat_pkg::SlotW'(s);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != lat_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign lb0 = in_long_address_in[63:56];
  assign lb3 = in_long_address_in[39:32];
  assign lb4 = in_long_address_in[31:24];

  // xxxxxxfffexxxxxx, translate and multicast clear, local set
  assign direct_ok = (lb3 == lat_pkg::ByteFf) && (lb4 == lat_pkg::ByteFe) &&
                     !lb0[lat_pkg::BitTr] && !lb0[lat_pkg::BitMu] &&
                     lb0[lat_pkg::BitGl];

  assign table_full = (count_r == lat_pkg::CountW'(lat_pkg::TableEntries));

  // slot and path chosen once the search is over
  always_comb begin
    if (hit_r) begin
      wr_slot = hit_slot_r;
      wr_path = lat_pkg::PATH_HIT;
    end else if (table_full) begin
      wr_slot = '0;
      wr_path = lat_pkg::PATH_FULL;
    end else begin
      wr_slot = count_r[lat_pkg::IdxW-1:0];
      wr_path = lat_pkg::PATH_NEW;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_eth_r  <= '0;
      own_long_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lat_pkg::REG_OWN_ETH:  own_eth_r  <= cfg_data[lat_pkg::EthW-1:0];
        lat_pkg::REG_OWN_LONG: own_long_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    key_nxt       = key_r;
    mid_nxt       = mid_r;
    low_nxt       = low_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    res_eth_nxt   = res_eth_r;
    res_long_nxt  = res_long_r;
    res_path_nxt  = res_path_r;
    res_slot_nxt  = res_slot_r;
    out_eth_nxt   = out_eth_r;
    out_long_nxt  = out_long_r;
    out_path_nxt  = out_path_r;
    out_slot_nxt  = out_slot_r;
    scan_ctrl     = '0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = wr_slot;
    ram_rd_en     = 1'b0;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lat_pkg::S_IDLE: begin
        if (accept) begin
          key_nxt      = {lb0, lb3, lb4};
          mid_nxt      = in_long_address_in[55:40];
          low_nxt      = in_long_address_in[23:0];
          hit_nxt      = 1'b0;
          res_eth_nxt  = '0;
          res_long_nxt = '0;
          res_slot_nxt = '0;
          state_nxt    = lat_pkg::S_EMIT;
          if (in_operation == lat_pkg::OP_ETH_TO_LONG) begin
            if (in_eth_address_in == own_eth_r) begin
              res_long_nxt = own_long_r;
              res_path_nxt = lat_pkg::PATH_OWN;
            end else begin
              // insert ff fe between ethernet bytes 2 and 3
              res_long_nxt = {in_eth_address_in[47:24], lat_pkg::ByteFf,
                              lat_pkg::ByteFe, in_eth_address_in[23:0]};
              res_path_nxt = lat_pkg::PATH_DIRECT;
            end
          end else if (in_long_address_in == own_long_r) begin
            res_eth_nxt  = own_eth_r;
            res_path_nxt = lat_pkg::PATH_OWN;
          end else if (direct_ok) begin
            res_eth_nxt  = {in_long_address_in[63:40], in_long_address_in[23:0]};
            res_path_nxt = lat_pkg::PATH_DIRECT;
          end else if (count_r == '0) begin
            // empty table, straight to the append
            state_nxt = lat_pkg::S_WRITE;
          end else begin
            state_nxt = lat_pkg::S_FETCH;
          end
        end
      end

      lat_pkg::S_FETCH: begin
        // read slot 0 and point the unit at it
        scan_ctrl.start = 1'b1;
        ram_rd_en       = 1'b1;
        state_nxt       = lat_pkg::S_SCAN;
      end

      lat_pkg::S_SCAN: begin
        ram_rd_en = 1'b1;
        if (scan_status.hit) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = scan_idx;
          state_nxt    = lat_pkg::S_WRITE;
        end else if (scan_status.last) begin
          state_nxt = lat_pkg::S_WRITE;
        end else begin
          scan_ctrl.advance = 1'b1;
        end
      end

      lat_pkg::S_WRITE: begin
        ram_wr_en    = 1'b1;
        res_eth_nxt  = {wr_slot_ext(wr_slot), 3'b110, mid_r, low_r};
        res_long_nxt = '0;
        res_path_nxt = wr_path;
        res_slot_nxt = wr_slot_ext(wr_slot);
        if (!hit_r && !table_full) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = lat_pkg::S_EMIT;
      end

      lat_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_eth_nxt   = res_eth_r;
          out_long_nxt  = res_long_r;
          out_path_nxt  = res_path_r;
          out_slot_nxt  = res_slot_r;
          state_nxt     = lat_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lat_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    mid_r      <= mid_nxt;
    low_r      <= low_nxt;
    hit_slot_r <= hit_slot_nxt;
    res_eth_r  <= res_eth_nxt;
    res_long_r <= res_long_nxt;
    res_path_r <= res_path_nxt;
    res_slot_r <= res_slot_nxt;
    out_eth_r  <= out_eth_nxt;
    out_long_r <= out_long_nxt;
    out_path_r <= out_path_nxt;
    out_slot_r <= out_slot_nxt;
  end

  lat_prefix_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (key_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lat_scan_unit u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (scan_ctrl),
    .key     (key_r),
    .rd_data (ram_rd_data),
    .count   (count_r),
    .idx     (scan_idx),
    .rd_addr (ram_rd_addr),
    .status  (scan_status)
  );

  assign out_valid            = out_valid_r;
  assign out_eth_address_out  = out_eth_r;
  assign out_long_address_out = out_long_r;
  assign out_path_taken       = out_path_r;
  assign out_table_slot       = out_slot_r;

  // fill count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lat_pkg::CountW'(lat_pkg::TableEntries))
    else $error("entry count beyond table depth");

  // a result only appears out of the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lat_pkg::S_EMIT))
    else $error("result loaded outside emit step");

  // table paths carry their slot in the first ethernet byte
  a_slot_encode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_path_r == lat_pkg::PATH_HIT || out_path_r == lat_pkg::PATH_NEW ||
                    out_path_r == lat_pkg::PATH_FULL)
    |-> out_eth_r[47:40] == {out_slot_r, 3'b110})
    else $error("slot not encoded in ethernet byte 0");

  // an append grows the table by one
  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lat_pkg::S_WRITE) && !hit_r && !table_full
    |=> count_r == lat_pkg::CountW'($past(count_r) + 1'b1))
    else $error("append did not bump entry count");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for link_address_translator_core: random and directed
// address items in both directions, bursty sender, stalling receiver, a
// mirror of the prefix table predicting every result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  // index values the block does not decode, writes there must be dropped
  localparam logic [lat_pkg::CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lat_pkg::CfgIdxW-1:0] REG_SPARE_3 = 2'd3;

  localparam int CycleLimit     = 600000;
  localparam int PhaseCount     = 5;
  localparam int RandomPerPhase = 205;
  localparam int PoolSize       = 40;
  localparam int LongHold       = 400;
  localparam int HoldMarkA      = 150;
  localparam int HoldMarkB      = 640;
  // drain margin, enough for a full-table search
  localparam int DrainCycles    = 40;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    logic                      op;
    logic [lat_pkg::LongW-1:0] lng;
    logic [lat_pkg::EthW-1:0]  eth;
  } address_req_t;

  typedef struct packed {
    logic [lat_pkg::EthW-1:0]  eth;
    logic [lat_pkg::LongW-1:0] lng;
    logic [lat_pkg::PathW-1:0] path;
    logic [lat_pkg::SlotW-1:0] slot;
  } translation_t;

  // dut signals, the inputs known from time zero
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [lat_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [lat_pkg::LongW-1:0]   cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_operation = 1'b0;
  logic [lat_pkg::LongW-1:0]   in_long_address_in = '0;
  logic [lat_pkg::EthW-1:0]    in_eth_address_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [lat_pkg::EthW-1:0]    out_eth_address_out;
  logic [lat_pkg::LongW-1:0]   out_long_address_out;
  logic [lat_pkg::PathW-1:0]   out_path_taken;
  logic [lat_pkg::SlotW-1:0]   out_table_slot;

  // items waiting to be offered, and translations waiting to come out
  address_req_t pending_items[$];
  translation_t expected_translations[$];

  // mirror of the block's registers and prefix table
  logic [lat_pkg::EthW-1:0]  own_eth_mirror = '0;
  logic [lat_pkg::LongW-1:0] own_long_mirror = '0;
  logic [lat_pkg::KeyW-1:0]  prefix_mirror[lat_pkg::TableEntries];
  int                        entry_mirror = 0;

  // prefixes reused by the random items so that the table sees hits
  logic [lat_pkg::KeyW-1:0] key_pool[PoolSize];

  logic in_taken = 1'b0;
  int   cfg_writes = 0;
  int   results_seen = 0;
  int   error_count = 0;

  // sender and receiver pacing
  int       burst_left = 1;
  int       gap_left = 0;
  int       hold_left = 0;
  int       hold_idx = 0;
  int       mode_left = 0;
  int       period = 4;
  int       pat_cnt = 0;
  rx_mode_t stall_mode = RX_FREE;

  link_address_translator_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_long_address_in   (in_long_address_in),
    .in_eth_address_in    (in_eth_address_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_eth_address_out  (out_eth_address_out),
    .out_long_address_out (out_long_address_out),
    .out_path_taken       (out_path_taken),
    .out_table_slot       (out_table_slot)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected translation of one item, updates the table mirror as the block does
  function automatic translation_t translate_item(input logic op,
                                                  input logic [lat_pkg::LongW-1:0] lng,
                                                  input logic [lat_pkg::EthW-1:0] eth);
    translation_t              r;
    logic [lat_pkg::KeyW-1:0]  key;
    logic [lat_pkg::SlotW-1:0] slot;
    logic [7:0]                head;
    int                        found;
    int                        i;
    r = '0;
    if (op == lat_pkg::OP_ETH_TO_LONG) begin
      // own address or ff fe inserted between bytes 2 and 3, never the table
      if (eth == own_eth_mirror) begin
        r.lng  = own_long_mirror;
        r.path = lat_pkg::PATH_OWN;
      end else begin
        r.lng  = {eth[47:24], lat_pkg::ByteFf, lat_pkg::ByteFe, eth[23:0]};
        r.path = lat_pkg::PATH_DIRECT;
      end
    end else if (lng == own_long_mirror) begin
      // own address wins over every other rule
      r.eth  = own_eth_mirror;
      r.path = lat_pkg::PATH_OWN;
    end else if (lng[39:32] == lat_pkg::ByteFf && lng[31:24] == lat_pkg::ByteFe &&
                 !lng[56 + lat_pkg::BitTr] && !lng[56 + lat_pkg::BitMu] &&
                 lng[56 + lat_pkg::BitGl]) begin
      // ff fe form, local unicast with translate clear: drop bytes 3 and 4
      r.eth  = {lng[63:40], lng[23:0]};
      r.path = lat_pkg::PATH_DIRECT;
    end else begin
      // prefix of bytes 0, 3, 4 searched among the valid entries
      key   = {lng[63:56], lng[39:32], lng[31:24]};
      found = -1;
      for (i = 0; i < entry_mirror; i++) begin
        if (found < 0 && prefix_mirror[i] == key) found = i;
      end
      if (found >= 0) begin
        slot   = found[lat_pkg::SlotW-1:0];
        r.path = lat_pkg::PATH_HIT;
      end else if (entry_mirror < lat_pkg::TableEntries) begin
        slot   = entry_mirror[lat_pkg::SlotW-1:0];
        entry_mirror++;
        r.path = lat_pkg::PATH_NEW;
      end else begin
        // table full on a miss: slot 0 is reused
        slot   = '0;
        r.path = lat_pkg::PATH_FULL;
      end
      prefix_mirror[slot] = key;
      head = {slot, 3'b000};
      head[lat_pkg::BitTr] = 1'b1;
      head[lat_pkg::BitGl] = 1'b1;
      r.eth  = {head, lng[55:40], lng[23:0]};
      r.slot = slot;
    end
    return r;
  endfunction

  // random item, weighted towards the interesting long address shapes
  function automatic address_req_t random_request();
    address_req_t             req;
    logic [7:0]               head;
    logic [lat_pkg::KeyW-1:0] key;
    int                       pick;
    req.op          = ($urandom_range(0, 99) < 30) ? lat_pkg::OP_ETH_TO_LONG
                                                    : lat_pkg::OP_LONG_TO_ETH;
    req.lng[63:32]  = $urandom;
    req.lng[31:0]   = $urandom;
    req.eth[47:32]  = 16'($urandom);
    req.eth[31:0]   = $urandom;
    pick            = $urandom_range(0, 99);
    if (req.op == lat_pkg::OP_ETH_TO_LONG) begin
      if (pick < 10) req.eth = own_eth_mirror;
    end else if (pick < 5) begin
      req.lng = own_long_mirror;
    end else if (pick < 25) begin
      // well-formed direct copy
      head = 8'($urandom);
      head[lat_pkg::BitTr] = 1'b0;
      head[lat_pkg::BitMu] = 1'b0;
      head[lat_pkg::BitGl] = 1'b1;
      req.lng[63:56] = head;
      req.lng[39:24] = {lat_pkg::ByteFf, lat_pkg::ByteFe};
    end else if (pick < 35) begin
      // ff fe with random flags, mostly falls through to the table
      req.lng[39:24] = {lat_pkg::ByteFf, lat_pkg::ByteFe};
    end else if (pick < 75) begin
      key = key_pool[$urandom_range(0, PoolSize - 1)];
      req.lng[63:56] = key[23:16];
      req.lng[39:24] = key[15:0];
    end
    return req;
  endfunction

  task automatic push_req(input logic op, input logic [lat_pkg::LongW-1:0] lng,
                          input logic [lat_pkg::EthW-1:0] eth);
    pending_items.push_back('{op: op, lng: lng, eth: eth});
  endtask

  // one register write, valid dropped on the falling edge after acceptance
  task automatic write_reg(input logic [lat_pkg::CfgIdxW-1:0] idx,
                           input logic [lat_pkg::LongW-1:0] value);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every queued item has been translated
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_translations.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // driver: bursts of items with random gaps, payload held while stalled
  always @(negedge clk) begin : driver
    address_req_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // not yet accepted, keep everything stable
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() != 0) begin
      item = pending_items.pop_front();
      in_valid           <= 1'b1;
      in_operation       <= item.op;
      in_long_address_in <= item.lng;
      in_eth_address_in  <= item.eth;
      if (burst_left <= 1) begin
        // end of burst: pick the next burst and the pause before it
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 4);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: a changing stall pattern, and two long hold-offs that fill the block
  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ((hold_idx == 0 && results_seen >= HoldMarkA) ||
                 (hold_idx == 1 && results_seen >= HoldMarkB)) begin
      out_stall <= 1'b1;
      hold_left <= LongHold;
      hold_idx  <= hold_idx + 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(32, 200);
        period     <= $urandom_range(2, 9);
      end else begin
        mode_left <= mode_left - 1;
      end
      pat_cnt <= (pat_cnt + 1) % period;
      case (stall_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
        RX_PERIODIC: out_stall <= (pat_cnt < period / 2);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // monitor: register writes, predictions at input acceptance, checks at output
  always @(posedge clk) begin : monitor
    translation_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lat_pkg::REG_OWN_ETH:  own_eth_mirror = cfg_data[lat_pkg::EthW-1:0];
          lat_pkg::REG_OWN_LONG: own_long_mirror = cfg_data;
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_translations.size() == 0) begin
          $error("result item with no translation pending");
          error_count++;
        end else begin
          want = expected_translations.pop_front();
          if (out_eth_address_out !== want.eth) begin
            $error("eth_address_out: expected %h, got %h", want.eth, out_eth_address_out);
            error_count++;
          end
          if (out_long_address_out !== want.lng) begin
            $error("long_address_out: expected %h, got %h", want.lng, out_long_address_out);
            error_count++;
          end
          if (out_path_taken !== want.path) begin
            $error("path_taken: expected %0d, got %0d", want.path, out_path_taken);
            error_count++;
          end
          if (out_table_slot !== want.slot) begin
            $error("table_slot: expected %0d, got %0d", want.slot, out_table_slot);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_translations.push_back(
          translate_item(in_operation, in_long_address_in, in_eth_address_in));
    end
  end

  // watchdog
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int p;
    int k;
    for (k = 0; k < PoolSize; k++) key_pool[k] = 24'($urandom);

    // synchronous reset
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (p = 0; p < PhaseCount; p++) begin
      // registers only change with the block idle
      case (p)
        0: begin
          // own addresses stay at reset zero, unknown indexes must be dropped
          write_reg(REG_SPARE_2, {$urandom, $urandom});
          write_reg(REG_SPARE_3, '1);
        end
        1: begin
          write_reg(lat_pkg::REG_OWN_ETH, '1);
          write_reg(lat_pkg::REG_OWN_LONG, '1);
        end
        2: begin
          write_reg(lat_pkg::REG_OWN_ETH, {$urandom, $urandom});
          write_reg(lat_pkg::REG_OWN_LONG, {$urandom, $urandom});
        end
        3: begin
          // own long address in the ff fe form: own match must win
          write_reg(lat_pkg::REG_OWN_ETH, {$urandom, $urandom});
          write_reg(lat_pkg::REG_OWN_LONG, 64'h0a5566fffe778899);
        end
        default: begin
          write_reg(lat_pkg::REG_OWN_ETH, '0);
          write_reg(lat_pkg::REG_OWN_LONG, '0);
          write_reg(REG_SPARE_2, '1);
        end
      endcase

      if (p == 0) begin
        push_req(lat_pkg::OP_LONG_TO_ETH, '0, '1);                   // own long at reset
        push_req(lat_pkg::OP_ETH_TO_LONG, '1, '0);                   // own ethernet at reset
        push_req(lat_pkg::OP_ETH_TO_LONG, '0, '1);                   // all-ones ethernet
        push_req(lat_pkg::OP_LONG_TO_ETH, '1, '0);                   // first table entry
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h021122fffe445566, '0); // direct copy
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'hfafffffffeffffff, '1); // direct, high bits
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h061122fffe445566, '0); // translate bit set
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h031122fffe445566, '0); // multicast bit set
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h001122fffe445566, '0); // local bit clear
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'hff0000ffff000000, '0); // hit on first entry
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h06aabbfffeccddee, '0); // hit, translate prefix
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h0000000000000001, '1); // new entry, near own
        push_req(lat_pkg::OP_LONG_TO_ETH, 64'h0211220000445566, '0); // flags ok, no ff fe
        push_req(lat_pkg::OP_ETH_TO_LONG, {$urandom, $urandom}, 48'h123456789abc);
        push_req(lat_pkg::OP_ETH_TO_LONG, '1, 48'h000000000001);
      end

      // own addresses of this setting, and one just beside the own ethernet
      push_req(lat_pkg::OP_LONG_TO_ETH, own_long_mirror, {16'($urandom), $urandom});
      push_req(lat_pkg::OP_ETH_TO_LONG, {$urandom, $urandom}, own_eth_mirror);
      push_req(lat_pkg::OP_ETH_TO_LONG, {$urandom, $urandom}, own_eth_mirror ^ 48'h1);

      for (k = 0; k < RandomPerPhase; k++) pending_items.push_back(random_request());

      // sender pauses until every translation of the phase is back
      wait_idle();
    end

    if (expected_translations.size() != 0) begin
      $error("%0d translations never came out", expected_translations.size());
    end
    if (error_count == 0 && expected_translations.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/lat_pkg.sv
hdl/lat_prefix_ram.sv
hdl/lat_scan_unit.sv
hdl/link_address_translator_core.sv
dv/tb_top.sv
